[hdl/lc3_instruction_executor_macros.svh]
// Assertion macros shared by the executor modules.
`ifndef LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define LC3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define LC3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lc3_pkg.sv]
// Package with opcodes, modes, status codes and address constants of the executor.
`timescale 1ns / 1ps

package lc3_pkg;

    localparam int ADDR_WIDTH = 16;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_HALTED = 2'd1;
    localparam logic [1:0] STAT_PRIV   = 2'd2;
    localparam logic [1:0] STAT_BADOP  = 2'd3;

    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_RTI  = 4'd8;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_RES  = 4'd13;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam logic [7:0] TRAP_GETC = 8'h20;
    localparam logic [7:0] TRAP_OUT  = 8'h21;
    localparam logic [7:0] TRAP_HALT = 8'h25;

    localparam logic [15:0] KB_STATUS = 16'hFE00;
    localparam logic [15:0] KB_DATA   = 16'hFE02;
    localparam logic [15:0] KB_READY  = 16'h8000;
    localparam logic [15:0] START_PC  = 16'h3000;
    localparam logic [15:0] START_PSR = 16'h0700;

    // Request to the word memory.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [15:0] wdata;
    } mem_req_t;

endpackage

[hdl/lc3_mem.sv]
// Single-port 64K x 16 word memory with keyboard status side effect.
`timescale 1ns / 1ps
`include "lc3_instruction_executor_macros.svh"

module lc3_mem
(
    input  logic             clk,
    input  logic             rst_n,
    input  lc3_pkg::mem_req_t req,
    input  logic             key_ready,
    input  logic [7:0]       key_code,
    output logic [15:0]      rdata
);

    logic [15:0] mem [0:(1 << lc3_pkg::ADDR_WIDTH) - 1];
    logic        kb_hit;
    logic [15:0] kb_word;
    logic        kb_reg;
    logic [15:0] kbw_reg;
    logic [15:0] raw_reg;

    assign kb_hit  = req.en && (req.addr == lc3_pkg::KB_STATUS);
    assign kb_word = key_ready ? lc3_pkg::KB_READY : 16'h0000;

    // Port access; a status read refreshes the status word, and a status touch also updates the data word when ready.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else if (kb_hit)
            begin
                mem[req.addr] <= kb_word;
            end
            raw_reg <= mem[req.addr];
        end
        if (kb_hit && key_ready)
        begin
            mem[lc3_pkg::KB_DATA] <= {8'h00, key_code};
        end
    end

    // Remember status reads so the read returns the fresh status word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_reg  <= 1'b0;
            kbw_reg <= 16'h0000;
        end
        else
        begin
            kb_reg  <= kb_hit && !req.we;
            kbw_reg <= kb_word;
        end
    end

    assign rdata = kb_reg ? kbw_reg : raw_reg;

    `LC3_ASSERT_NEXT(a_kb_read, clk, rst_n, kb_hit && !req.we && key_ready,
        rdata == lc3_pkg::KB_READY, "status read not ready")
    `LC3_ASSERT_NEXT(a_kb_idle, clk, rst_n, kb_hit && !req.we && !key_ready,
        rdata == 16'h0000, "status read not clear")

endmodule

[hdl/lc3_instruction_executor.sv]
// Top level: LC-3 style core sequencer over a private word memory.
// Usage:
//   Input beats arrive on s_axis_*; tdata carries mode, address, data,
//   key_ready and key_code from the lowest bit up. Each input beat gives
//   exactly one output beat on m_axis_* with status, program_counter,
//   read_data, char_valid and char_out.
//   The result is registered in the finish step, after the fetch step for
//   write and read beats and after fetch, decode and up to two memory steps
//   for executed instructions (a halted execute beat or the unused mode goes
//   straight there): the single memory port serves the fetch, up to two
//   dependent reads (LDI, STI, RTI) and one store, each read taking an issue
//   and a capture step. The next beat can be taken in the cycle after.
//   One item is in work at a time; the next beat is taken once the result
//   sits in the output register, so it may proceed while that result waits.
//   Reset puts PC at 0x3000, PSR at 0x0700 and clears the halted flag;
//   registers and memory hold no defined value until written.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer waits in its finish step until that register frees up.
`timescale 1ns / 1ps
`include "lc3_instruction_executor_macros.svh"

module lc3_instruction_executor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], address[17:2], data[33:18], key_ready[34], key_code[42:35]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], program_counter[17:2], read_data[33:18], char_valid[34],
    // char_out[42:35]
    output logic [47:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_DECODE, S_MEM1, S_MEM2, S_DONE
    } state_t;

    state_t      state_reg;
    logic [1:0]  mode_reg;
    logic [15:0] addr_reg, data_reg;
    logic        kr_reg;
    logic [7:0]  kc_reg;
    logic [15:0] ir_reg, pc_reg, psr_reg, ea_reg;
    logic        halted_reg;
    logic [15:0] gpr [0:7];
    logic [1:0]  err_reg;
    logic [15:0] rd_reg;
    logic        cv_reg;
    logic [7:0]  co_reg;
    logic        ov_reg;
    logic [47:0] od_reg;
    logic        wait_reg;
    lc3_pkg::mem_req_t req;
    logic [15:0] rdata;

    logic [3:0]  op;
    logic [2:0]  dr, sr1, sr2;
    logic [15:0] pcoff9, baseoff6, op2, pcoff11;

    assign op      = ir_reg[15:12];
    assign dr      = ir_reg[11:9];
    assign sr1     = ir_reg[8:6];
    assign sr2     = ir_reg[2:0];
    assign pcoff9  = pc_reg + {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign pcoff11 = pc_reg + {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign baseoff6 = gpr[sr1] + {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign op2     = ir_reg[5] ? {{11{ir_reg[4]}}, ir_reg[4:0]} : gpr[sr2];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    // Plain write beats never trigger the keyboard side effect.
    lc3_mem u_mem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .key_ready (kr_reg && (mode_reg != lc3_pkg::MODE_WRITE)),
        .key_code  (kc_reg),
        .rdata     (rdata)
    );

    function automatic logic [2:0] cc(input logic [15:0] v);
        cc = v[15] ? 3'b100 : ((v == 16'h0000) ? 3'b010 : 3'b001);
    endfunction

    // Drive the memory port from the current step.
    always_comb
    begin
        req = '0;
        case (state_reg)
            S_FETCH:
            begin
                req.en = !wait_reg;
                req.we = (mode_reg == lc3_pkg::MODE_WRITE);
                req.addr = (mode_reg == lc3_pkg::MODE_EXEC) ? pc_reg : addr_reg;
                req.wdata = data_reg;
            end
            S_MEM1, S_MEM2:
            begin
                req.en = !wait_reg;
                req.addr = ea_reg;
                req.we = (op == lc3_pkg::OP_ST || op == lc3_pkg::OP_STR)
                    || (op == lc3_pkg::OP_STI && state_reg == S_MEM2);
                req.wdata = gpr[dr];
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // Sequencer: fetch, decode, up to two memory steps, finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= lc3_pkg::START_PC;
            psr_reg    <= lc3_pkg::START_PSR;
            halted_reg <= 1'b0;
            ov_reg     <= 1'b0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            if (ov_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        mode_reg <= s_axis_tdata[1:0];
                        addr_reg <= s_axis_tdata[17:2];
                        data_reg <= s_axis_tdata[33:18];
                        kr_reg   <= s_axis_tdata[34];
                        kc_reg   <= s_axis_tdata[42:35];
                        err_reg  <= lc3_pkg::STAT_OK;
                        rd_reg   <= 16'h0000;
                        cv_reg   <= 1'b0;
                        co_reg   <= 8'h00;
                        wait_reg <= 1'b0;
                        if (s_axis_tdata[1:0] == lc3_pkg::MODE_EXEC && halted_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (s_axis_tdata[1:0] == lc3_pkg::MODE_EXEC
                            || s_axis_tdata[1:0] == lc3_pkg::MODE_READ
                            || s_axis_tdata[1:0] == lc3_pkg::MODE_WRITE)
                        begin
                            state_reg <= S_FETCH;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_FETCH:
                begin
                    if (mode_reg == lc3_pkg::MODE_WRITE)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        if (mode_reg == lc3_pkg::MODE_READ)
                        begin
                            rd_reg    <= rdata;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ir_reg    <= rdata;
                            pc_reg    <= pc_reg + 16'd1;
                            state_reg <= S_DECODE;
                        end
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_DONE;
                    case (op)
                        lc3_pkg::OP_BR:
                        begin
                            if ((psr_reg[2:0] & dr) != 3'b000)
                            begin
                                pc_reg <= pcoff9;
                            end
                        end
                        lc3_pkg::OP_ADD:
                        begin
                            gpr[dr] <= gpr[sr1] + op2;
                            psr_reg[2:0] <= cc(gpr[sr1] + op2);
                        end
                        lc3_pkg::OP_AND:
                        begin
                            gpr[dr] <= gpr[sr1] & op2;
                            psr_reg[2:0] <= cc(gpr[sr1] & op2);
                        end
                        lc3_pkg::OP_NOT:
                        begin
                            gpr[dr] <= ~gpr[sr1];
                            psr_reg[2:0] <= cc(~gpr[sr1]);
                        end
                        lc3_pkg::OP_LEA:
                        begin
                            gpr[dr] <= pcoff9;
                            psr_reg[2:0] <= cc(pcoff9);
                        end
                        lc3_pkg::OP_LD, lc3_pkg::OP_ST, lc3_pkg::OP_LDI,
                        lc3_pkg::OP_STI:
                        begin
                            ea_reg    <= pcoff9;
                            state_reg <= S_MEM1;
                        end
                        lc3_pkg::OP_LDR, lc3_pkg::OP_STR:
                        begin
                            ea_reg    <= baseoff6;
                            state_reg <= S_MEM1;
                        end
                        lc3_pkg::OP_JSR:
                        begin
                            gpr[7] <= pc_reg;
                            pc_reg <= ir_reg[11] ? pcoff11 : gpr[sr1];
                        end
                        lc3_pkg::OP_JMP:
                        begin
                            pc_reg <= gpr[sr1];
                        end
                        lc3_pkg::OP_RTI:
                        begin
                            if (psr_reg[15])
                            begin
                                err_reg <= lc3_pkg::STAT_PRIV;
                            end
                            else
                            begin
                                ea_reg    <= gpr[6];
                                state_reg <= S_MEM1;
                            end
                        end
                        lc3_pkg::OP_TRAP:
                        begin
                            gpr[7] <= pc_reg;
                            case (ir_reg[7:0])
                                lc3_pkg::TRAP_GETC:
                                begin
                                    gpr[0] <= {8'h00, kc_reg};
                                    psr_reg[2:0] <= cc({8'h00, kc_reg});
                                end
                                lc3_pkg::TRAP_OUT:
                                begin
                                    cv_reg <= 1'b1;
                                    co_reg <= gpr[0][7:0];
                                end
                                lc3_pkg::TRAP_HALT:
                                begin
                                    halted_reg <= 1'b1;
                                end
                                default:
                                begin
                                    cv_reg <= 1'b0;
                                end
                            endcase
                        end
                        default:
                        begin
                            err_reg <= lc3_pkg::STAT_BADOP;
                        end
                    endcase
                end
                S_MEM1:
                begin
                    if (req.we)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        case (op)
                            lc3_pkg::OP_LDI, lc3_pkg::OP_STI:
                            begin
                                ea_reg    <= rdata;
                                state_reg <= S_MEM2;
                            end
                            lc3_pkg::OP_RTI:
                            begin
                                pc_reg    <= rdata;
                                gpr[6]    <= gpr[6] + 16'd1;
                                ea_reg    <= gpr[6] + 16'd1;
                                state_reg <= S_MEM2;
                            end
                            default:
                            begin
                                gpr[dr]      <= rdata;
                                psr_reg[2:0] <= cc(rdata);
                                state_reg    <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MEM2:
                begin
                    if (req.we)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else
                    begin
                        wait_reg  <= 1'b0;
                        state_reg <= S_DONE;
                        if (op == lc3_pkg::OP_RTI)
                        begin
                            psr_reg <= rdata;
                            gpr[6]  <= gpr[6] + 16'd1;
                        end
                        else
                        begin
                            gpr[dr]      <= rdata;
                            psr_reg[2:0] <= cc(rdata);
                        end
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ov_reg <= 1'b1;
                        od_reg <= {5'd0, co_reg, cv_reg, rd_reg, pc_reg,
                            (err_reg != lc3_pkg::STAT_OK) ? err_reg :
                            (halted_reg ? lc3_pkg::STAT_HALTED : lc3_pkg::STAT_OK)};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LC3_ASSERT_IMP(a_one_port, clk, rst_n, req.we, req.en,
        "memory write without enable")
    `LC3_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg,
        "halted flag cleared")
    `LC3_ASSERT_IMP(a_accept_idle, clk, rst_n, s_axis_tvalid && s_axis_tready,
        state_reg == S_IDLE, "beat taken while busy")
    `LC3_ASSERT_NEXT(a_hold_out, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")

endmodule

[bench/lc3_instruction_executor_tb.sv]
// Testbench for lc3_instruction_executor: directed and random beats checked against a core predictor.
`timescale 1ns / 1ps

module lc3_instruction_executor_tb;

    // Input beat fields, lowest bit first from the bottom of the struct
    typedef struct packed {
        logic [7:0]  key_code;
        logic        key_ready;
        logic [15:0] data;
        logic [15:0] address;
        logic [1:0]  mode;
    } cmd_beat_t;

    // Result beat fields
    typedef struct packed {
        logic [7:0]  char_out;
        logic        char_valid;
        logic [15:0] read_data;
        logic [15:0] program_counter;
        logic [1:0]  status;
    } result_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    // Core state as predicted
    logic [15:0] core_regs [8];
    logic [15:0] core_pc = lc3_pkg::START_PC;
    logic [15:0] core_psr = lc3_pkg::START_PSR;
    logic        core_halted = 1'b0;
    logic [15:0] core_mem [logic [15:0]];
    logic        key_ready_now;
    logic [7:0]  key_code_now;

    result_beat_t pending_results[$];
    logic [15:0]  loaded_addrs[$];
    int errors = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int hold_until = 0;
    bit priv_stack = 1'b0;

    lc3_instruction_executor DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Keyboard status side effect on any core access to the status word
    function automatic void kb_touch(logic [15:0] a);
        if (a == lc3_pkg::KB_STATUS)
        begin
            if (key_ready_now)
            begin
                core_mem[lc3_pkg::KB_STATUS] = lc3_pkg::KB_READY;
                core_mem[lc3_pkg::KB_DATA] = {8'h00, key_code_now};
            end
            else
                core_mem[lc3_pkg::KB_STATUS] = 16'h0000;
        end
    endfunction

    function automatic logic [15:0] core_read(logic [15:0] a);
        kb_touch(a);
        return core_mem.exists(a) ? core_mem[a] : 16'h0000;
    endfunction

    function automatic void core_write(logic [15:0] a, logic [15:0] v);
        kb_touch(a);
        core_mem[a] = v;
    endfunction

    function automatic void set_flags(logic [15:0] v);
        core_psr[2:0] = v[15] ? 3'b100 : ((v == 16'h0000) ? 3'b010 : 3'b001);
    endfunction

    // Run one instruction; returns STAT_OK or an error status
    function automatic logic [1:0] run_instruction(output logic cv, output logic [7:0] co);
        logic [15:0] ins, pc, off9, base6, opnd, tmp;
        logic [2:0]  dr, sr1;
        bit          flags;
        cv = 1'b0;
        co = 8'h00;
        flags = 1'b0;
        ins = core_read(core_pc);
        core_pc = core_pc + 16'd1;
        pc = core_pc;
        dr = ins[11:9];
        sr1 = ins[8:6];
        off9 = pc + {{7{ins[8]}}, ins[8:0]};
        base6 = core_regs[sr1] + {{10{ins[5]}}, ins[5:0]};
        opnd = ins[5] ? {{11{ins[4]}}, ins[4:0]} : core_regs[ins[2:0]];
        case (ins[15:12])
            lc3_pkg::OP_BR:  if ((core_psr[2:0] & dr) != 3'b000) core_pc = off9;
            lc3_pkg::OP_ADD: begin core_regs[dr] = core_regs[sr1] + opnd; flags = 1'b1; end
            lc3_pkg::OP_LD:  begin core_regs[dr] = core_read(off9); flags = 1'b1; end
            lc3_pkg::OP_ST:  core_write(off9, core_regs[dr]);
            lc3_pkg::OP_JSR:
            begin
                tmp = core_regs[sr1];
                core_regs[7] = pc;
                core_pc = ins[11] ? pc + {{5{ins[10]}}, ins[10:0]} : tmp;
            end
            lc3_pkg::OP_AND: begin core_regs[dr] = core_regs[sr1] & opnd; flags = 1'b1; end
            lc3_pkg::OP_LDR: begin core_regs[dr] = core_read(base6); flags = 1'b1; end
            lc3_pkg::OP_STR: core_write(base6, core_regs[dr]);
            lc3_pkg::OP_RTI:
            begin
                if (core_psr[15])
                    return lc3_pkg::STAT_PRIV;
                core_pc = core_read(core_regs[6]);
                core_regs[6] = core_regs[6] + 16'd1;
                core_psr = core_read(core_regs[6]);
                core_regs[6] = core_regs[6] + 16'd1;
            end
            lc3_pkg::OP_NOT: begin core_regs[dr] = ~core_regs[sr1]; flags = 1'b1; end
            lc3_pkg::OP_LDI:
            begin
                core_regs[dr] = core_read(core_read(off9));
                flags = 1'b1;
            end
            lc3_pkg::OP_STI: core_write(core_read(off9), core_regs[dr]);
            lc3_pkg::OP_JMP: core_pc = core_regs[sr1];
            lc3_pkg::OP_LEA: begin core_regs[dr] = off9; flags = 1'b1; end
            lc3_pkg::OP_TRAP:
            begin
                core_regs[7] = pc;
                case (ins[7:0])
                    lc3_pkg::TRAP_GETC:
                    begin
                        core_regs[0] = {8'h00, key_code_now};
                        set_flags(core_regs[0]);
                    end
                    lc3_pkg::TRAP_OUT:
                    begin
                        cv = 1'b1;
                        co = core_regs[0][7:0];
                    end
                    lc3_pkg::TRAP_HALT: core_halted = 1'b1;
                    default: ;
                endcase
            end
            default: return lc3_pkg::STAT_BADOP;
        endcase
        if (flags)
            set_flags(core_regs[dr]);
        return lc3_pkg::STAT_OK;
    endfunction

    function automatic result_beat_t predict_result(cmd_beat_t b);
        result_beat_t r;
        logic [1:0]   err;
        logic         cv;
        logic [7:0]   co;
        err = lc3_pkg::STAT_OK;
        cv = 1'b0;
        co = 8'h00;
        r = '0;
        key_ready_now = b.key_ready;
        key_code_now = b.key_code;
        if (b.mode == lc3_pkg::MODE_WRITE)
            core_mem[b.address] = b.data;
        else if (b.mode == lc3_pkg::MODE_READ)
            r.read_data = core_read(b.address);
        else if (b.mode == lc3_pkg::MODE_EXEC && !core_halted)
            err = run_instruction(cv, co);
        r.status = (err != lc3_pkg::STAT_OK) ? err :
                   (core_halted ? lc3_pkg::STAT_HALTED : lc3_pkg::STAT_OK);
        r.program_counter = core_pc;
        r.char_valid = cv;
        r.char_out = co;
        return r;
    endfunction

    // Value a core read would see, without side effects
    function automatic logic [15:0] peek_word(logic [15:0] a, logic kr);
        if (a == lc3_pkg::KB_STATUS)
            return kr ? lc3_pkg::KB_READY : 16'h0000;
        return core_mem.exists(a) ? core_mem[a] : 16'h0000;
    endfunction

    function automatic logic [15:0] random_instruction();
        logic [15:0] w;
        w = 16'($urandom);
        if (w[15:12] == lc3_pkg::OP_TRAP)
        begin
            case ($urandom_range(3))
                0: w[7:0] = lc3_pkg::TRAP_GETC;
                1: w[7:0] = lc3_pkg::TRAP_OUT;
                default: ;
            endcase
            if (w[7:0] == lc3_pkg::TRAP_HALT)
                w[7:0] = 8'h23;
        end
        return w;
    endfunction

    // Send one beat, record its expected result, then maybe idle
    task automatic send_beat(logic [1:0] md, logic [15:0] a, logic [15:0] d,
                             logic kr, logic [7:0] kc);
        cmd_beat_t b;
        b.mode = md;
        b.address = a;
        b.data = d;
        b.key_ready = kr;
        b.key_code = kc;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_result(b));
        if (md == lc3_pkg::MODE_WRITE)
            loaded_addrs.push_back(a);
        if ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_word(logic [15:0] a, logic [15:0] d);
        send_beat(lc3_pkg::MODE_WRITE, a, d, 1'($urandom), 8'($urandom));
    endtask

    task automatic read_word(logic [15:0] a, logic kr);
        send_beat(lc3_pkg::MODE_READ, a, 16'($urandom), kr, 8'($urandom));
    endtask

    // Load a word that the next instruction reads if it was never loaded
    task automatic load_if_blank(logic [15:0] a);
        if (a != lc3_pkg::KB_STATUS && !core_mem.exists(a))
            write_word(a, 16'($urandom));
    endtask

    // Execute one instruction, loading it at PC first when place is set
    task automatic exec_instruction(logic [15:0] ins, bit place);
        logic        kr;
        logic [7:0]  kc;
        logic [15:0] w, ptr, sp;
        kr = 1'($urandom);
        kc = 8'($urandom);
        if (!core_halted)
        begin
            w = peek_word(core_pc, kr);
            if (!place && core_mem.exists(core_pc) && w[15:12] == lc3_pkg::OP_TRAP
                && w[7:0] == lc3_pkg::TRAP_HALT)
                place = 1'b1;
            if (place && core_pc != lc3_pkg::KB_STATUS)
                write_word(core_pc, ins);
            load_if_blank(core_pc);
            w = peek_word(core_pc, kr);
            ptr = core_pc + 16'd1 + {{7{w[8]}}, w[8:0]};
            sp = core_regs[6];
            case (w[15:12])
                lc3_pkg::OP_LD, lc3_pkg::OP_STI: load_if_blank(ptr);
                lc3_pkg::OP_LDR: load_if_blank(core_regs[w[8:6]] + {{10{w[5]}}, w[5:0]});
                lc3_pkg::OP_LDI:
                begin
                    load_if_blank(ptr);
                    load_if_blank(peek_word(ptr, kr));
                end
                lc3_pkg::OP_RTI:
                begin
                    // build a return frame: PC, then PSR with user bit chosen by the test
                    if (!core_psr[15] && sp != lc3_pkg::KB_STATUS
                        && sp + 16'd1 != lc3_pkg::KB_STATUS)
                    begin
                        write_word(sp, 16'($urandom));
                        write_word(sp + 16'd1, {priv_stack, 15'($urandom)});
                    end
                    else if (!core_psr[15])
                    begin
                        load_if_blank(sp);
                        load_if_blank(sp + 16'd1);
                    end
                end
                default: ;
            endcase
        end
        send_beat(lc3_pkg::MODE_EXEC, 16'($urandom), 16'($urandom), kr, kc);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count < hold_until)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(string name, logic [15:0] e, logic [15:0] g);
        if (g !== e)
        begin
            $display("%0t: %s mismatch expected %h actual %h", $time, name, e, g);
            errors++;
        end
    endfunction

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        result_beat_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[42:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("program_counter", want.program_counter, got.program_counter);
                check_field("read_data", want.read_data, got.read_data);
                check_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
                check_field("char_out", 16'(want.char_out), 16'(got.char_out));
            end
        end
    end

    // Every operation, field extremes and the keyboard status word
    task automatic test_directed();
        for (int r = 0; r < 8; r++)
            exec_instruction({lc3_pkg::OP_LEA, 3'(r),
                              (r == 0) ? 9'h0FF : (r == 1) ? 9'h100 : 9'(r * 5)}, 1'b1);
        exec_instruction({lc3_pkg::OP_ADD, 3'd2, 3'd0, 1'b0, 2'b00, 3'd1}, 1'b1);
        exec_instruction({lc3_pkg::OP_ADD, 3'd3, 3'd3, 1'b1, 5'h10}, 1'b1);
        exec_instruction({lc3_pkg::OP_ADD, 3'd4, 3'd4, 1'b1, 5'h0F}, 1'b1);
        exec_instruction({lc3_pkg::OP_AND, 3'd5, 3'd0, 1'b1, 5'h00}, 1'b1);
        exec_instruction({lc3_pkg::OP_AND, 3'd5, 3'd1, 1'b0, 2'b00, 3'd2}, 1'b1);
        exec_instruction({lc3_pkg::OP_NOT, 3'd6, 3'd1, 6'h3F}, 1'b1);
        exec_instruction({lc3_pkg::OP_TRAP, 4'h0, lc3_pkg::TRAP_GETC}, 1'b1);
        exec_instruction({lc3_pkg::OP_TRAP, 4'h0, lc3_pkg::TRAP_OUT}, 1'b1);
        exec_instruction({lc3_pkg::OP_TRAP, 4'h0, 8'h22}, 1'b1);
        exec_instruction({lc3_pkg::OP_BR, 3'b111, 9'd5}, 1'b1);
        exec_instruction({lc3_pkg::OP_BR, 3'b000, 9'h1FF}, 1'b1);
        exec_instruction({lc3_pkg::OP_LD, 3'd1, 9'd3}, 1'b1);
        exec_instruction({lc3_pkg::OP_LDR, 3'd2, 3'd3, 6'h20}, 1'b1);
        exec_instruction({lc3_pkg::OP_LDR, 3'd2, 3'd4, 6'h1F}, 1'b1);
        exec_instruction({lc3_pkg::OP_LDI, 3'd4, 9'd1}, 1'b1);
        exec_instruction({lc3_pkg::OP_ST, 3'd0, 9'h1FF}, 1'b1);
        exec_instruction({lc3_pkg::OP_STR, 3'd1, 3'd2, 6'h05}, 1'b1);
        exec_instruction({lc3_pkg::OP_STI, 3'd5, 9'd2}, 1'b1);
        exec_instruction({lc3_pkg::OP_JSR, 1'b1, 11'h3FF}, 1'b1);
        exec_instruction({lc3_pkg::OP_JSR, 1'b1, 11'h400}, 1'b1);
        exec_instruction({lc3_pkg::OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00}, 1'b1);
        exec_instruction({lc3_pkg::OP_JMP, 3'd0, 3'd3, 6'h00}, 1'b1);
        exec_instruction({lc3_pkg::OP_RES, 12'hFFF}, 1'b1);
        exec_instruction({lc3_pkg::OP_RTI, 12'h000}, 1'b1);
        write_word(16'hFFFF, 16'hFFFF);
        read_word(16'hFFFF, 1'b1);
        write_word(16'h0000, 16'h0000);
        read_word(16'h0000, 1'b0);
        read_word(lc3_pkg::KB_STATUS, 1'b1);
        read_word(lc3_pkg::KB_DATA, 1'b0);
        read_word(lc3_pkg::KB_STATUS, 1'b0);
    endtask

    // Mostly instructions with loaded operands, plus plain loads and reads
    task automatic test_random(int n, int gap, int stall);
        int pick;
        gap_pct = gap;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                exec_instruction(random_instruction(), $urandom_range(9) < 8);
            else if (pick < 85)
                write_word(16'($urandom), 16'($urandom));
            else if ($urandom_range(7) == 0)
                read_word(lc3_pkg::KB_STATUS, 1'($urandom));
            else
                read_word(loaded_addrs[$urandom_range(loaded_addrs.size() - 1)], 1'($urandom));
        end
        wait_drain();
    endtask

    // Long receiver hold-off while the sender keeps pushing
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        hold_until = cycle_count + 300;
        for (int i = 0; i < 60; i++)
            exec_instruction(random_instruction(), 1'b1);
        wait_drain();
    endtask

    // Return into user mode, then RTI must fault; keep the stack clear of the code
    task automatic test_privilege();
        priv_stack = 1'b1;
        exec_instruction({lc3_pkg::OP_LEA, 3'd6, 9'd16}, 1'b1);
        exec_instruction({lc3_pkg::OP_RTI, 12'h000}, 1'b1);
        exec_instruction({lc3_pkg::OP_RTI, 12'h000}, 1'b1);
        for (int i = 0; i < 10; i++)
            exec_instruction(random_instruction(), 1'b1);
        wait_drain();
    endtask

    // Halt, then execution stalls while loads and reads still work
    task automatic test_halt();
        exec_instruction({lc3_pkg::OP_TRAP, 4'h0, lc3_pkg::TRAP_HALT}, 1'b1);
        for (int i = 0; i < 3; i++)
            exec_instruction(random_instruction(), 1'b0);
        write_word(16'h1234, 16'hBEEF);
        read_word(16'h1234, 1'b0);
        read_word(lc3_pkg::KB_STATUS, 1'b1);
        wait_drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drain();
        test_random(165, 0, 0);
        test_random(165, 53, 0);
        test_random(165, 0, 53);
        test_random(165, 32, 32);
        test_backpressure();
        test_privilege();
        test_halt();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
